// ===== rtl/nmd_pkg.sv =====
// ----------------------------------------------------------------------------
// nmd_pkg
// Shared types and codes of the node id to mac directory.
// ----------------------------------------------------------------------------
package nmd_pkg;

	localparam int ID_W     = 8;
	localparam int ID_DEPTH = 1 << ID_W;
	localparam int MAC_W    = 48;
	localparam int SLOT_W   = 8;
	localparam int STATUS_W = 3;

	localparam logic OP_UPDATE = 1'b0;
	localparam logic OP_LOOKUP = 1'b1;

	localparam logic [STATUS_W-1:0] ST_UPDATED  = 3'd0;
	localparam logic [STATUS_W-1:0] ST_INSERTED = 3'd1;
	localparam logic [STATUS_W-1:0] ST_FULL     = 3'd2;
	localparam logic [STATUS_W-1:0] ST_HIT      = 3'd3;
	localparam logic [STATUS_W-1:0] ST_MISS     = 3'd4;

	typedef struct packed {
		logic              hit;
		logic [SLOT_W-1:0] slot;
	} map_rd_t;

	typedef struct packed {
		logic              en;
		logic [ID_W-1:0]   node_id;
		logic [SLOT_W-1:0] slot;
	} map_wr_t;

endpackage

// ===== rtl/node_id_mac_directory.sv =====
// ----------------------------------------------------------------------------
// node_id_mac_directory
// Directory of node ids to mac addresses with update, first free insert
// and lookup requests.
// ----------------------------------------------------------------------------
// a request passes the slot map read and stage one registers, then the
//   status and mac read registers to its result strobe; no new request is
//   taken while one is in stage one, for its mac memory read or write
// busy is high for the cycle after a request is taken; results cannot stall
// reset clears the id valid bits and the fill count at once, no clearing pass
module node_id_mac_directory #(
	parameter int NUM_ENTRIES = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic                         opcode,
	input  logic [nmd_pkg::ID_W-1:0]     node_id,
	input  logic [nmd_pkg::MAC_W-1:0]    mac_address,
	output logic                         done,
	output logic [nmd_pkg::STATUS_W-1:0] status,
	output logic [nmd_pkg::MAC_W-1:0]    found_mac
);

	localparam int IDX_W = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
	localparam int CNT_W = $clog2(NUM_ENTRIES + 1);

	logic                         accept;
	logic                         valid_s1;
	logic                         op_s1;
	logic [nmd_pkg::ID_W-1:0]     id_s1;
	logic [nmd_pkg::MAC_W-1:0]    mac_s1;
	logic                         valid_s2;
	logic [nmd_pkg::STATUS_W-1:0] status_s2;
	logic [CNT_W-1:0]             fill_q;

	nmd_pkg::map_rd_t             map_rd;
	nmd_pkg::map_wr_t             map_wr;
	logic                         full;
	logic                         mac_wr_en;
	logic                         mac_rd_en;
	logic [IDX_W-1:0]             mac_idx;
	logic [nmd_pkg::MAC_W-1:0]    mac_rd_data;
	logic [nmd_pkg::STATUS_W-1:0] status_next;

	assign accept = start & ~valid_s1;
	assign busy   = valid_s1;
	assign full   = (fill_q == CNT_W'(NUM_ENTRIES));

	nmd_slot_map u_slot_map (
		.clk    (clk),
		.arst_n (arst_n),
		.rd_en  (accept),
		.rd_id  (node_id),
		.rd     (map_rd),
		.wr     (map_wr)
	);

	always_comb begin
		mac_wr_en      = 1'b0;
		mac_rd_en      = 1'b0;
		mac_idx        = map_rd.slot[IDX_W-1:0];
		map_wr.en      = 1'b0;
		map_wr.node_id = id_s1;
		map_wr.slot    = nmd_pkg::SLOT_W'(fill_q[IDX_W-1:0]);
		status_next    = nmd_pkg::ST_MISS;
		if (op_s1 == nmd_pkg::OP_LOOKUP) begin
			mac_rd_en   = valid_s1 & map_rd.hit;
			status_next = map_rd.hit ? nmd_pkg::ST_HIT : nmd_pkg::ST_MISS;
		end else if (map_rd.hit) begin
			mac_wr_en   = valid_s1;
			status_next = nmd_pkg::ST_UPDATED;
		end else if (!full) begin
			mac_wr_en   = valid_s1;
			map_wr.en   = valid_s1;
			mac_idx     = fill_q[IDX_W-1:0];
			status_next = nmd_pkg::ST_INSERTED;
		end else begin
			status_next = nmd_pkg::ST_FULL;
		end
	end

	nmd_mac_store #(
		.DEPTH (NUM_ENTRIES),
		.IDX_W (IDX_W)
	) u_mac_store (
		.clk     (clk),
		.wr_en   (mac_wr_en),
		.wr_idx  (mac_idx),
		.wr_data (mac_s1),
		.rd_en   (mac_rd_en),
		.rd_idx  (mac_idx),
		.rd_data (mac_rd_data)
	);

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			fill_q   <= '0;
		end else begin
			valid_s1 <= accept;
			valid_s2 <= valid_s1;
			if (map_wr.en) begin
				fill_q <= fill_q + CNT_W'(1);
			end
		end
	end

	// request payload
	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1  <= opcode;
			id_s1  <= node_id;
			mac_s1 <= mac_address;
		end
		if (valid_s1) begin
			status_s2 <= status_next;
		end
	end

	assign done      = valid_s2;
	assign status    = status_s2;
	assign found_mac = (status_s2 == nmd_pkg::ST_HIT) ? mac_rd_data : '0;

endmodule

// ===== rtl/nmd_slot_map.sv =====
// ----------------------------------------------------------------------------
// nmd_slot_map
// Maps every node id to its table slot: one valid bit per id and a
// synchronous slot memory indexed by id.
// ----------------------------------------------------------------------------
module nmd_slot_map (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   rd_en,
	input  logic [nmd_pkg::ID_W-1:0] rd_id,
	output nmd_pkg::map_rd_t       rd,
	input  nmd_pkg::map_wr_t       wr
);

	logic [nmd_pkg::ID_DEPTH-1:0] id_valid_q;
	logic [nmd_pkg::SLOT_W-1:0]   slot_mem [nmd_pkg::ID_DEPTH];
	nmd_pkg::map_rd_t             rd_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			id_valid_q <= '0;
		end else if (wr.en) begin
			id_valid_q[wr.node_id] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr.en) begin
			slot_mem[wr.node_id] <= wr.slot;
		end
		if (rd_en) begin
			rd_q.hit  <= id_valid_q[rd_id];
			rd_q.slot <= slot_mem[rd_id];
		end
	end

	assign rd = rd_q;

endmodule

// ===== rtl/nmd_mac_store.sv =====
// ----------------------------------------------------------------------------
// nmd_mac_store
// Mac address memory: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module nmd_mac_store #(
	parameter int DEPTH = 16,
	parameter int IDX_W = 4
) (
	input  logic                      clk,
	input  logic                      wr_en,
	input  logic [IDX_W-1:0]          wr_idx,
	input  logic [nmd_pkg::MAC_W-1:0] wr_data,
	input  logic                      rd_en,
	input  logic [IDX_W-1:0]          rd_idx,
	output logic [nmd_pkg::MAC_W-1:0] rd_data
);

	logic [nmd_pkg::MAC_W-1:0] mem [DEPTH];
	logic [nmd_pkg::MAC_W-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_idx] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_idx];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ===== rtl/nmd_checker.sv =====
// ----------------------------------------------------------------------------
// nmd_checker
// Port level checks of the node id to mac directory.
// ----------------------------------------------------------------------------
module nmd_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         start,
	input logic                         busy,
	input logic                         done,
	input logic [nmd_pkg::STATUS_W-1:0] status,
	input logic [nmd_pkg::MAC_W-1:0]    found_mac
);

	// every accepted request is followed by its result strobe
	a_result_timing: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> ##1 done)
		else $error("result strobe missing two cycles after request");

	a_busy_after_req: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("busy low right after a request");

	// no result strobe without a matching accepted request
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, 2))
		else $error("result strobe without request");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (status == nmd_pkg::ST_UPDATED || status == nmd_pkg::ST_INSERTED ||
			status == nmd_pkg::ST_FULL || status == nmd_pkg::ST_HIT ||
			status == nmd_pkg::ST_MISS))
		else $error("status code out of range");

	a_mac_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && status != nmd_pkg::ST_HIT |-> found_mac == '0)
		else $error("found_mac nonzero without a lookup hit");

endmodule

bind node_id_mac_directory nmd_checker u_nmd_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.start     (start),
	.busy      (busy),
	.done      (done),
	.status    (status),
	.found_mac (found_mac)
);

// ===== bench/node_id_mac_directory_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// node_id_mac_directory_test
// Self-checking bench for the node id to mac directory. A short directed
// table walks empty lookups, insert, overwrite, fill to capacity and the
// dropped insert on a full table. Random requests follow, mostly aimed at
// stored ids, under several sender idle patterns. Every reply is checked
// against its typed-in reply or else an in-bench model of the table.
// ----------------------------------------------------------------------------
module node_id_mac_directory_test;

	localparam int NUM_ENTRIES  = 16;
	localparam int RANDOM_ITEMS = 1800;
	localparam int CYCLE_LIMIT  = 200000;
	localparam logic [nmd_pkg::MAC_W-1:0] MAC_ONES = '1;

	typedef struct packed {
		logic [nmd_pkg::STATUS_W-1:0] status;
		logic [nmd_pkg::MAC_W-1:0]    mac;
	} reply_t;

	typedef struct {
		logic                      op;
		logic [nmd_pkg::ID_W-1:0]  id;
		logic [nmd_pkg::MAC_W-1:0] mac;
		bit                        fixed;
		reply_t                    reply;
	} stim_row_t;

	logic                         clk         = 1'b0;
	logic                         arst_n      = 1'b0;
	logic                         start       = 1'b0;
	logic                         opcode      = nmd_pkg::OP_UPDATE;
	logic [nmd_pkg::ID_W-1:0]     node_id     = '0;
	logic [nmd_pkg::MAC_W-1:0]    mac_address = '0;
	logic                         busy;
	logic                         done;
	logic [nmd_pkg::STATUS_W-1:0] status;
	logic [nmd_pkg::MAC_W-1:0]    found_mac;

	// typed-in reply travelling with the request
	bit     fixed_en    = 1'b0;
	reply_t fixed_reply = '0;

	bit                        dir_valid [NUM_ENTRIES];
	logic [nmd_pkg::ID_W-1:0]  dir_node  [NUM_ENTRIES];
	logic [nmd_pkg::MAC_W-1:0] dir_mac   [NUM_ENTRIES];

	reply_t    reply_q[$];
	stim_row_t directed_rows[$];
	int        fail_count  = 0;
	int        cycle_count = 0;

	node_id_mac_directory #(
		.NUM_ENTRIES(NUM_ENTRIES)
	) u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.opcode     (opcode),
		.node_id    (node_id),
		.mac_address(mac_address),
		.done       (done),
		.status     (status),
		.found_mac  (found_mac)
	);

	always #6 clk = ~clk;

	function automatic reply_t directory_apply(logic op, logic [nmd_pkg::ID_W-1:0] id,
			logic [nmd_pkg::MAC_W-1:0] mac);
		reply_t r;
		int hit_idx;
		int free_idx;
		hit_idx  = -1;
		free_idx = -1;
		r.mac    = '0;
		for (int i = 0; i < NUM_ENTRIES; i++) begin
			if (dir_valid[i] && dir_node[i] == id && hit_idx < 0)
				hit_idx = i;
			if (!dir_valid[i] && free_idx < 0)
				free_idx = i;
		end
		if (op == nmd_pkg::OP_LOOKUP) begin
			if (hit_idx >= 0) begin
				r.status = nmd_pkg::ST_HIT;
				r.mac    = dir_mac[hit_idx];
			end else begin
				r.status = nmd_pkg::ST_MISS;
			end
		end else if (hit_idx >= 0) begin
			dir_mac[hit_idx] = mac;
			r.status = nmd_pkg::ST_UPDATED;
		end else if (free_idx >= 0) begin
			dir_valid[free_idx] = 1'b1;
			dir_node[free_idx]  = id;
			dir_mac[free_idx]   = mac;
			r.status = nmd_pkg::ST_INSERTED;
		end else begin
			r.status = nmd_pkg::ST_FULL;
		end
		return r;
	endfunction

	function automatic void add_row(logic op, logic [nmd_pkg::ID_W-1:0] id,
			logic [nmd_pkg::MAC_W-1:0] mac, bit fixed,
			logic [nmd_pkg::STATUS_W-1:0] st, logic [nmd_pkg::MAC_W-1:0] fmac);
		stim_row_t row;
		row.op           = op;
		row.id           = id;
		row.mac          = mac;
		row.fixed        = fixed;
		row.reply.status = st;
		row.reply.mac    = fmac;
		directed_rows.push_back(row);
	endfunction

	task automatic send_request(logic op, logic [nmd_pkg::ID_W-1:0] id,
			logic [nmd_pkg::MAC_W-1:0] mac, bit fixed, reply_t fixed_val, int idle_pct);
		start       <= 1'b1;
		opcode      <= op;
		node_id     <= id;
		mac_address <= mac;
		fixed_en    <= fixed;
		fixed_reply <= fixed_val;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		if ($urandom_range(0, 99) < idle_pct) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
	endtask

	// reply check and request capture
	always @(posedge clk) begin
		reply_t want;
		reply_t pred;
		if (arst_n) begin
			if (done === 1'b1) begin
				if (reply_q.size() == 0) begin
					$error("reply with no request pending: status %0d found_mac %h",
						status, found_mac);
					fail_count++;
				end else begin
					want = reply_q.pop_front();
					if (status !== want.status) begin
						$error("status mismatch: expected %0d, actual %0d",
							want.status, status);
						fail_count++;
					end
					if (found_mac !== want.mac) begin
						$error("found_mac mismatch: expected %h, actual %h",
							want.mac, found_mac);
						fail_count++;
					end
				end
			end
			if (start && !busy) begin
				pred = directory_apply(opcode, node_id, mac_address);
				reply_q.push_back(fixed_en ? fixed_reply : pred);
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("node_id_mac_directory_test: FAIL");
			$finish;
		end
	end

	initial begin
		int idle_pct [4];
		reply_t no_reply;
		logic rop;
		logic [nmd_pkg::ID_W-1:0] rid;
		logic [nmd_pkg::MAC_W-1:0] rmac;
		int pick;
		idle_pct = '{0, 70, 0, 32};
		no_reply = '0;
		for (int i = 0; i < NUM_ENTRIES; i++)
			dir_valid[i] = 1'b0;

		// empty table, insert, overwrite, lookup ignores its mac field
		add_row(nmd_pkg::OP_LOOKUP, 8'd0,   MAC_ONES, 1'b1, nmd_pkg::ST_MISS, '0);
		add_row(nmd_pkg::OP_LOOKUP, 8'd255, '0,       1'b1, nmd_pkg::ST_MISS, '0);
		add_row(nmd_pkg::OP_UPDATE, 8'd0,   MAC_ONES, 1'b1, nmd_pkg::ST_INSERTED, '0);
		add_row(nmd_pkg::OP_LOOKUP, 8'd0,   '0,       1'b1, nmd_pkg::ST_HIT, MAC_ONES);
		add_row(nmd_pkg::OP_UPDATE, 8'd0,   '0,       1'b1, nmd_pkg::ST_UPDATED, '0);
		add_row(nmd_pkg::OP_LOOKUP, 8'd0,   MAC_ONES, 1'b1, nmd_pkg::ST_HIT, '0);
		add_row(nmd_pkg::OP_UPDATE, 8'd255, 48'h5555_5555_5555, 1'b1,
			nmd_pkg::ST_INSERTED, '0);
		add_row(nmd_pkg::OP_UPDATE, 8'd255, 48'hAAAA_AAAA_AAAA, 1'b1,
			nmd_pkg::ST_UPDATED, '0);
		add_row(nmd_pkg::OP_LOOKUP, 8'd255, '0, 1'b1, nmd_pkg::ST_HIT, 48'hAAAA_AAAA_AAAA);
		// fill the remaining entries
		for (int i = 1; i <= NUM_ENTRIES - 2; i++)
			add_row(nmd_pkg::OP_UPDATE, nmd_pkg::ID_W'(i),
				nmd_pkg::MAC_W'({$urandom, $urandom}), 1'b0, nmd_pkg::ST_INSERTED, '0);
		// full table
		add_row(nmd_pkg::OP_UPDATE, 8'd128, MAC_ONES, 1'b1, nmd_pkg::ST_FULL, '0);
		add_row(nmd_pkg::OP_LOOKUP, 8'd128, MAC_ONES, 1'b1, nmd_pkg::ST_MISS, '0);
		add_row(nmd_pkg::OP_UPDATE, 8'd7,   48'h0123_4567_89AB, 1'b1,
			nmd_pkg::ST_UPDATED, '0);
		add_row(nmd_pkg::OP_LOOKUP, 8'd7,   '0, 1'b0, nmd_pkg::ST_HIT, '0);

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i])
			send_request(directed_rows[i].op, directed_rows[i].id, directed_rows[i].mac,
				directed_rows[i].fixed, directed_rows[i].reply, 0);

		for (int phase = 0; phase < 4; phase++) begin
			for (int n = 0; n < RANDOM_ITEMS / 4; n++) begin
				rop  = 1'($urandom_range(0, 1));
				rmac = nmd_pkg::MAC_W'({$urandom, $urandom});
				pick = $urandom_range(0, NUM_ENTRIES - 1);
				if ($urandom_range(0, 99) < 75 && dir_valid[pick])
					rid = dir_node[pick];
				else
					rid = nmd_pkg::ID_W'($urandom_range(0, 255));
				send_request(rop, rid, rmac, 1'b0, no_reply, idle_pct[phase]);
			end
		end
		start <= 1'b0;

		@(posedge clk);
		while (reply_q.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);

		if (fail_count == 0)
			$display("node_id_mac_directory_test: PASS");
		else
			$display("node_id_mac_directory_test: FAIL");
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/nmd_pkg.sv
rtl/nmd_slot_map.sv
rtl/nmd_mac_store.sv
rtl/node_id_mac_directory.sv
rtl/nmd_checker.sv
bench/node_id_mac_directory_test.sv
